/* design/u2l_pkg.sv */
// package for the utf-8 to latin-1 decoder
// byte class masks, character constants and the item structs; no dependencies
package u2l_pkg;

    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_CODE = 8'hf0;
    localparam logic [7:0] PAYLOAD5_MASK = 8'h1f;
    localparam logic [7:0] PAYLOAD6_MASK = 8'h3f;
    localparam logic [7:0] CHAR_UNKNOWN  = 8'h3f;  // '?'

    localparam logic [1:0] CONT_NONE = 2'd0;
    localparam logic [1:0] CONT_ONE  = 2'd1;
    localparam logic [1:0] CONT_TWO  = 2'd2;
    localparam logic [1:0] CONT_THREE = 2'd3;

    // one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       last;
    } t_out_item;

    // decoder sequence state
    typedef struct packed {
        logic [1:0] continuations_left;
        logic       two_byte_seq;
        logic [4:0] lead_payload;
    } t_seq_state;

endpackage

/* design/u2l_in_stage.sv */
// input register stage of the utf-8 to latin-1 decoder
// depends on u2l_pkg for the input item struct
module u2l_in_stage import u2l_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_take,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    // a held item leaves when the next stage takes it
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* design/u2l_decode.sv */
// byte decoder with sequence state for the utf-8 to latin-1 decoder
// depends on u2l_pkg for masks, constants and structs
module u2l_decode import u2l_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output logic      o_produce,
    output t_out_item o_result
);

    t_seq_state r_state;
    t_seq_state n_state;
    logic       emit;
    logic [7:0] ch;
    logic [7:0] b;
    logic [1:0] left_dec;

    assign b        = i_item.in_byte;
    assign left_dec = r_state.continuations_left - 2'd1;

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        ch      = 8'h00;
        if ((b & CONT_MASK) == CONT_CODE) begin
            if (r_state.continuations_left != CONT_NONE) begin
                n_state.continuations_left = left_dec;
                if (left_dec == CONT_NONE) begin
                    emit = 1'b1;
                    // code point fits latin-1 only if lead payload bits 4:2 are zero
                    if (r_state.two_byte_seq && (r_state.lead_payload[4:2] == 3'd0)) begin
                        ch = {r_state.lead_payload[1:0], b[5:0] & PAYLOAD6_MASK[5:0]};
                    end else begin
                        ch = CHAR_UNKNOWN;
                    end
                end
            end
        end else begin
            n_state = '0;
            priority if (b[7] == 1'b0) begin
                emit = 1'b1;
                ch   = b;
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                n_state.two_byte_seq       = 1'b1;
                n_state.lead_payload       = b[4:0] & PAYLOAD5_MASK[4:0];
                n_state.continuations_left = CONT_ONE;
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                n_state.continuations_left = CONT_TWO;
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
                n_state.continuations_left = CONT_THREE;
            end else begin
                n_state = '0;
            end
        end
        if (n_state.continuations_left == CONT_NONE) begin
            n_state.two_byte_seq = 1'b0;
            n_state.lead_payload = 5'd0;
        end
        if (i_item.end_of_text) begin
            n_state = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_produce           = emit || i_item.end_of_text;
    assign o_result.out_char   = emit ? ch : 8'h00;
    assign o_result.char_valid = emit;
    assign o_result.last       = i_item.end_of_text;

endmodule

/* design/u2l_out_stage.sv */
// result register stage of the utf-8 to latin-1 decoder
// depends on u2l_pkg for the result item struct
module u2l_out_stage import u2l_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    output logic      o_can_load,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    logic      r_valid;
    t_out_item r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/utf8_to_latin1_decoder_core.sv */
// top level of the utf-8 to latin-1 decoder
// depends on u2l_pkg, u2l_in_stage, u2l_decode and u2l_out_stage
//
// usage
//   input channel: i_valid / o_ready with i_in_byte and i_end_of_text, one
//   utf-8 byte per item; i_end_of_text marks the final byte of a text
//   output channel: o_valid / i_ready with o_out_char, o_char_valid, o_last
//   an item gives zero or one result: ascii bytes and completed sequences give
//   a character ('?' when the code point is above 0xff or the sequence is
//   three or four bytes long); leads, stray continuations and bytes 0xf8-0xff
//   give nothing; the end-of-text item always gives a result with o_last set,
//   a bare marker (o_char_valid low, o_out_char zero) if it had no character
// order: an accepted item is held in the input register, then decoded into
//   the result register once that register can load
// throughput: one item per cycle while results are taken, set by the single
//   decode stage between the two registers
// reset: synchronous on i_rst_n low; both stages empty, no sequence pending
// stall: while i_ready is low the held result stays; the input register still
//   takes one more item, then o_ready drops until the result is taken
module utf8_to_latin1_decoder_core import u2l_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_last
);

    t_in_item  in_item;
    t_in_item  held_item;
    logic      held_valid;
    logic      can_load;
    logic      fire;
    logic      produce;
    t_out_item dec_result;
    t_out_item out_result;

    assign in_item.in_byte     = i_in_byte;
    assign in_item.end_of_text = i_end_of_text;

    // held item is decoded when the result register can take its result
    assign fire = held_valid && can_load;

    u2l_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (fire),
        .o_item  (held_item)
    );

    // sequence state advances only on a decoded item
    u2l_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (held_item),
        .o_produce (produce),
        .o_result  (dec_result)
    );

    // items that give no result just retire without loading
    u2l_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && produce),
        .i_result   (dec_result),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_out_char   = out_result.out_char;
    assign o_char_valid = out_result.char_valid;
    assign o_last       = out_result.last;

`ifndef SYNTHESIS
    // a bare marker always closes the text and carries no character
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> (o_last && (o_out_char == 8'h00)))
        else $error("bare end marker malformed");

    // an ascii byte that is decoded shows up unchanged next cycle
    a_ascii_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !held_item.in_byte[7]) |=>
        (o_valid && o_char_valid && (o_out_char == $past(held_item.in_byte))))
        else $error("ascii byte not passed through");

    // input backpressure only when the held item is blocked by a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (held_valid && o_valid && !i_ready))
        else $error("input stalled without output stall");

    // an end-of-text item that is decoded always gives a closing result
    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && held_item.end_of_text) |=> (o_valid && o_last))
        else $error("end of text without closing result");
`endif

endmodule

/* tb/sv/u2l_decode_checker.sv */
`timescale 1ns / 1ps
// result checker for the utf-8 to latin-1 decoder core
// watches both channels, keeps its own decoder state; depends on u2l_pkg
module u2l_decode_checker import u2l_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_char_valid,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending_count
);

    localparam int REPORT_LIMIT = 10;

    // decoder state as seen from the byte stream
    logic [1:0] cont_left;
    logic       two_byte;
    logic [4:0] lead_bits;

    t_out_item  char_q[$];
    int         fails;

    task automatic clear_seq();
        cont_left = CONT_NONE;
        two_byte  = 1'b0;
        lead_bits = 5'd0;
    endtask

    // decode one byte and queue the character or end marker it gives
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        logic        emit;
        logic [7:0]  ch;
        logic [10:0] code_point;
        t_out_item   res;
        emit = 1'b0;
        ch   = 8'h00;
        if ((b & CONT_MASK) == CONT_CODE) begin
            // stray continuations fall through with nothing to do
            if (cont_left != CONT_NONE) begin
                cont_left = cont_left - 2'd1;
                if (cont_left == CONT_NONE) begin
                    emit = 1'b1;
                    if (two_byte) begin
                        code_point = {lead_bits, b[5:0]};
                        ch = (code_point <= 11'h0ff) ? code_point[7:0] : CHAR_UNKNOWN;
                    end else begin
                        ch = CHAR_UNKNOWN;
                    end
                end
            end
        end else begin
            // any other byte drops a pending sequence first
            clear_seq();
            if (b[7] == 1'b0) begin
                emit = 1'b1;
                ch   = b;
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                two_byte  = 1'b1;
                lead_bits = b[4:0];
                cont_left = CONT_ONE;
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                cont_left = CONT_TWO;
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
                cont_left = CONT_THREE;
            end
        end
        if (cont_left == CONT_NONE) begin
            two_byte  = 1'b0;
            lead_bits = 5'd0;
        end
        if (eot) begin
            clear_seq();
            res.out_char   = emit ? ch : 8'h00;
            res.char_valid = emit;
            res.last       = 1'b1;
            char_q.push_back(res);
        end else if (emit) begin
            res.out_char   = ch;
            res.char_valid = 1'b1;
            res.last       = 1'b0;
            char_q.push_back(res);
        end
    endtask

    task automatic flag_error(input string what, input t_out_item want, input t_out_item got);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $write("%0t ns: %s: expected char %02h valid %0b last %0b,",
                   $realtime, what, want.out_char, want.char_valid, want.last);
            $display(" got char %02h valid %0b last %0b",
                     got.out_char, got.char_valid, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            clear_seq();
            char_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.out_char   = i_out_char;
                got.char_valid = i_char_valid;
                got.last       = i_last;
                if (char_q.size() == 0) begin
                    want = '0;
                    flag_error("result with nothing expected", want, got);
                end else begin
                    want = char_q.pop_front();
                    if (got.out_char != want.out_char || got.char_valid != want.char_valid
                            || got.last != want.last) begin
                        flag_error("result mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_byte, i_end_of_text);
            end
        end
        o_fail_count    <= fails;
        o_pending_count <= char_q.size();
    end

endmodule

/* tb/sv/utf8_to_latin1_decoder_core_test.sv */
`timescale 1ns / 1ps
// top of the utf-8 to latin-1 decoder test: clock, reset, byte stimulus and verdict
// depends on u2l_pkg, utf8_to_latin1_decoder_core and u2l_decode_checker
module utf8_to_latin1_decoder_core_test import u2l_pkg::*;;

    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_EVERY  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_char_valid;
    logic       o_last;

    int         fail_count;
    int         pending_count;
    int         cycle_count = 0;

    // when set, a side runs back to back for a while
    bit         send_calm = 1'b0;
    bit         take_calm = 1'b0;

    always #2 i_clk = ~i_clk;

    utf8_to_latin1_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_char_valid  (o_char_valid),
        .o_last        (o_last)
    );

    u2l_decode_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_text   (i_end_of_text),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_char      (o_out_char),
        .i_char_valid    (o_char_valid),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("utf8_to_latin1_decoder_core_test: FAIL");
            $finish;
        end
    end

    // offer one byte, after a random gap, and hold it until the core takes it;
    // returns at the accepting edge so a zero gap keeps valid high
    task automatic send_item(input logic [7:0] b, input logic eot);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop sending until every queued character has come out
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // result side: random stalls per result, with calm stretches
    initial begin
        int unsigned stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        logic [7:0] text_q[$];
        int         sent;
        int         drain_mark;
        int         n_chars;
        int         kind;
        int         cut;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed bytes: ascii extremes, each sequence length, the drop cases
        send_item(8'h41, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h7f, 1'b0);
        send_item(8'hc3, 1'b0);     // two-byte, representable
        send_item(8'ha9, 1'b0);
        send_item(8'hc0, 1'b0);     // overlong form decoding to character zero
        send_item(8'h80, 1'b0);
        send_item(8'hc4, 1'b0);     // code point just above latin-1
        send_item(8'h80, 1'b0);
        send_item(8'he2, 1'b0);     // three-byte sequence
        send_item(8'h82, 1'b0);
        send_item(8'hac, 1'b0);
        send_item(8'hf0, 1'b0);     // four-byte sequence
        send_item(8'h9f, 1'b0);
        send_item(8'h98, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hbf, 1'b0);     // stray continuation
        send_item(8'hc3, 1'b0);     // lead killed by an invalid byte
        send_item(8'hf8, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'he2, 1'b0);     // sequence cut short by ascii
        send_item(8'h41, 1'b0);
        send_item(8'hc3, 1'b1);     // text ends on a lead: bare marker
        send_item(8'hc2, 1'b0);
        send_item(8'hbf, 1'b1);     // text ends on a completed character
        send_item(8'h5a, 1'b1);     // one-byte text
        send_item(8'h80, 1'b1);     // stray byte closing a text: bare marker
        drain();

        // random texts, mostly well-formed characters with some noise mixed in
        sent       = 0;
        drain_mark = DRAIN_EVERY;
        while (sent < RANDOM_ITEMS) begin
            text_q.delete();
            n_chars = $urandom_range(1, 40);
            repeat (n_chars) begin
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    text_q.push_back(8'($urandom_range(8'h01, 8'h7f)));
                end else if (kind < 60) begin
                    // at least half the leads give latin-1 code points
                    if ($urandom_range(0, 1) == 0)
                        text_q.push_back(8'($urandom_range(8'hc0, 8'hc3)));
                    else
                        text_q.push_back(8'($urandom_range(8'hc0, 8'hdf)));
                    text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end else if (kind < 70) begin
                    text_q.push_back(8'($urandom_range(8'he0, 8'hef)));
                    repeat (2) text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end else if (kind < 80) begin
                    text_q.push_back(8'($urandom_range(8'hf0, 8'hf7)));
                    repeat (3) text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end else if (kind < 87) begin
                    text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end else if (kind < 92) begin
                    text_q.push_back(8'($urandom_range(8'hf8, 8'hff)));
                end else begin
                    // three- or four-byte lead with zero to two continuations, mostly truncated
                    cut = $urandom_range(0, 2);
                    text_q.push_back(8'($urandom_range(8'he0, 8'hf7)));
                    repeat (cut) text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
                end
            end
            foreach (text_q[k]) send_item(text_q[k], k == text_q.size() - 1);
            sent += text_q.size();
            if (sent >= drain_mark) begin
                drain();
                drain_mark += DRAIN_EVERY;
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("utf8_to_latin1_decoder_core_test: PASS");
        end else begin
            $display("utf8_to_latin1_decoder_core_test: FAIL");
        end
        $finish;
    end

endmodule
